// ===== sv/sfr_pkg.sv =====
`default_nettype none
package sfr_pkg;

  // Phase codes
  localparam logic [1:0] PHASE_HUNT = 2'd0;
  localparam logic [1:0] PHASE_ADDR = 2'd1;
  localparam logic [1:0] PHASE_DATA = 2'd2;

  // Event codes
  localparam logic [1:0] EV_NONE     = 2'd0;
  localparam logic [1:0] EV_ACCEPTED = 2'd1;
  localparam logic [1:0] EV_ADDR_REJ = 2'd2;
  localparam logic [1:0] EV_CRC_FAIL = 2'd3;

  // Register indexes and reset values
  localparam logic REG_OWN_ADDR   = 1'b0;
  localparam logic REG_GROUP_ADDR = 1'b1;
  localparam logic [7:0] OWN_ADDR_RESET   = 8'hA1;
  localparam logic [7:0] GROUP_ADDR_RESET = 8'hAF;
  localparam logic [7:0] BROADCAST_ADDR   = 8'hFF;

  localparam logic [3:0] ADDR_BITS = 4'd8;
  localparam logic [3:0] DATA_BITS = 4'd12;
  localparam logic [2:0] HUNT_LAST = 3'd7;

  localparam int PADDR_W = 3;

  typedef struct packed {
    logic [7:0] own_address;
    logic [7:0] group_address;
  } cfg_t;

  typedef struct packed {
    logic [1:0] event_res;
    logic [7:0] payload;
    logic [1:0] phase;
  } res_t;

  // Preamble matcher for 1000100, overlap aware.
  function automatic logic [2:0] hunt_next(input logic [2:0] st, input logic b);
    logic [2:0] nx;
    begin
      nx = 3'd0;
      unique case (st)
        3'd0: nx = b ? 3'd1 : 3'd0;
        3'd1: nx = b ? 3'd1 : 3'd2;
        3'd2: nx = b ? 3'd1 : 3'd3;
        3'd3: nx = b ? 3'd1 : 3'd4;
        3'd4: nx = b ? 3'd5 : 3'd0;
        3'd5: nx = b ? 3'd1 : 3'd6;
        3'd6: nx = b ? 3'd1 : 3'd7;
        3'd7: nx = b ? 3'd1 : 3'd4;
        default: nx = 3'd0;
      endcase
      return nx;
    end
  endfunction

endpackage
`default_nettype wire

// ===== sv/sfr_bit_if.sv =====
`default_nettype none
interface sfr_bit_if;
  logic valid;
  logic ready;
  logic line_bit;

  modport source (output valid, output line_bit, input ready);
  modport sink (input valid, input line_bit, output ready);
endinterface
`default_nettype wire

// ===== sv/sfr_res_if.sv =====
`default_nettype none
interface sfr_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_res;
  logic [7:0] payload;
  logic [1:0] phase;

  modport source (output valid, output event_res, output payload, output phase,
                  input ready);
  modport sink (input valid, input event_res, input payload, input phase,
                output ready);
endinterface
`default_nettype wire

// ===== sv/sfr_apb_regs.sv =====
`default_nettype none
module sfr_apb_regs
  import sfr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  output cfg_t                    cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Register writes; word index is address bit 2.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.own_address   <= OWN_ADDR_RESET;
      cfg.group_address <= GROUP_ADDR_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_OWN_ADDR:   cfg.own_address   <= pwdata[7:0];
        REG_GROUP_ADDR: cfg.group_address <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read mux.
  always_comb begin
    unique case (paddr[2])
      REG_OWN_ADDR:   prdata = {24'd0, cfg.own_address};
      REG_GROUP_ADDR: prdata = {24'd0, cfg.group_address};
      default:        prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/sfr_core.sv =====
`default_nettype none
module sfr_core
  import sfr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic step_en,
  input  wire logic line_bit,
  input  wire cfg_t cfg,
  output res_t      result
);

  logic [2:0]  hunt_state, hunt_state_next;
  logic [1:0]  phase_reg, phase_reg_next;
  logic [11:0] shift_bits, shift_bits_next;
  logic [3:0]  bit_count, bit_count_next;
  logic [3:0]  crc_bits, crc_bits_next;

  logic [7:0]  addr_sh;
  logic [11:0] data_sh;
  logic [3:0]  cnt_inc;
  logic [3:0]  crc_new;
  logic        fb;
  logic        addr_hit;

  assign addr_sh  = {shift_bits[6:0], line_bit};
  assign data_sh  = {shift_bits[10:0], line_bit};
  assign cnt_inc  = bit_count + 4'd1;
  assign fb       = crc_bits[3] ^ line_bit;
  assign crc_new  = {crc_bits[2:0], 1'b0} ^ {2'b00, fb, fb};
  assign addr_hit = (addr_sh == cfg.own_address) || (addr_sh == cfg.group_address) ||
                    (addr_sh == BROADCAST_ADDR);

  // One step of the deframer for the current bit.
  always_comb begin
    hunt_state_next = hunt_state;
    phase_reg_next  = phase_reg;
    shift_bits_next = shift_bits;
    bit_count_next  = bit_count;
    crc_bits_next   = crc_bits;
    result.event_res = EV_NONE;
    result.payload   = 8'd0;

    case (phase_reg)
      PHASE_ADDR: begin
        if (bit_count >= ADDR_BITS) begin
          // Mismatched address: this bit rejects the frame.
          result.event_res = EV_ADDR_REJ;
          hunt_state_next  = 3'd0;
          phase_reg_next   = PHASE_HUNT;
          shift_bits_next  = 12'd0;
          bit_count_next   = 4'd0;
          crc_bits_next    = 4'd0;
        end else if (cnt_inc == ADDR_BITS && addr_hit) begin
          phase_reg_next  = PHASE_DATA;
          shift_bits_next = 12'd0;
          bit_count_next  = 4'd0;
          crc_bits_next   = 4'd0;
        end else begin
          shift_bits_next = {4'd0, addr_sh};
          bit_count_next  = cnt_inc;
        end
      end
      PHASE_DATA: begin
        if (cnt_inc >= DATA_BITS) begin
          if (crc_new == 4'd0) begin
            result.event_res = EV_ACCEPTED;
            result.payload   = data_sh[11:4];
          end else begin
            result.event_res = EV_CRC_FAIL;
          end
          hunt_state_next = 3'd0;
          phase_reg_next  = PHASE_HUNT;
          shift_bits_next = 12'd0;
          bit_count_next  = 4'd0;
          crc_bits_next   = 4'd0;
        end else begin
          shift_bits_next = data_sh;
          crc_bits_next   = crc_new;
          bit_count_next  = cnt_inc;
        end
      end
      default: begin
        // Preamble hunt; the unused phase code behaves the same.
        if (hunt_state == HUNT_LAST) begin
          hunt_state_next = 3'd0;
          phase_reg_next  = PHASE_ADDR;
          shift_bits_next = 12'd0;
          bit_count_next  = 4'd0;
          crc_bits_next   = 4'd0;
        end else begin
          hunt_state_next = hunt_next(hunt_state, line_bit);
          phase_reg_next  = PHASE_HUNT;
        end
      end
    endcase

    result.phase = phase_reg_next;
  end

  // State registers advance once per consumed item.
  always_ff @(posedge clk) begin
    if (rst) begin
      hunt_state <= 3'd0;
      phase_reg  <= PHASE_HUNT;
      shift_bits <= 12'd0;
      bit_count  <= 4'd0;
      crc_bits   <= 4'd0;
    end else if (step_en) begin
      hunt_state <= hunt_state_next;
      phase_reg  <= phase_reg_next;
      shift_bits <= shift_bits_next;
      bit_count  <= bit_count_next;
      crc_bits   <= crc_bits_next;
    end
  end

endmodule
`default_nettype wire

// ===== sv/serial_frame_receiver_crc4.sv =====
// Bit-serial frame receiver. Each input item is one line bit; each accepted bit
// yields exactly one result item carrying the event code, the payload of an
// accepted frame and the phase after that bit. The block hunts for the
// preamble 1000100 plus one more bit, checks an eight-bit address against the
// unicast, group and broadcast values, and then checks twelve data bits with a
// CRC-4 (x^4+x+1). Throughput is one bit per clock cycle, sustained while the
// result side keeps taking items; the bit passes an input register and then
// the combinational step logic into the result register, from which the
// result is presented. Addresses are written through the APB port at byte
// offsets 0x0 and 0x4; the user must write them only while the block is
// idle, which the block itself does not enforce.
`default_nettype none
module serial_frame_receiver_crc4
  import sfr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  sfr_bit_if.sink                 rx,
  sfr_res_if.source               res,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready
);

  cfg_t cfg;
  res_t step_res;
  res_t out_res;
  logic in_valid;
  logic in_bit;
  logic out_valid;
  logic advance;

  sfr_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The held bit moves on when the result register is free or being emptied.
  assign advance  = in_valid && (!out_valid || res.ready);
  assign rx.ready = !in_valid || advance;

  sfr_core u_core (
    .clk      (clk),
    .rst      (rst),
    .step_en  (advance),
    .line_bit (in_bit),
    .cfg      (cfg),
    .result   (step_res)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.ready) begin
      in_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.ready && rx.valid) begin
      in_bit <= rx.line_bit;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= step_res;
    end
  end

  assign res.valid     = out_valid;
  assign res.event_res = out_res.event_res;
  assign res.payload   = out_res.payload;
  assign res.phase     = out_res.phase;

  // Every finished frame event sends the receiver back to preamble hunt.
  a_event_to_hunt: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.event_res != EV_NONE) |-> (res.phase == PHASE_HUNT))
    else $error("frame event without return to hunt");

  // Payload is only carried by an accepted frame.
  a_payload_zero: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.event_res != EV_ACCEPTED) |-> (res.payload == 8'd0))
    else $error("payload on a non-accepted result");

  // The unused phase code never appears.
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.phase != 2'd3))
    else $error("invalid phase code");

  // A result is produced only when a held bit was consumed.
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    ($rose(out_valid)) |-> $past(in_valid))
    else $error("result without a consumed bit");

endmodule
`default_nettype wire
